[design/fsc_pkg.sv]
`default_nettype none
package fsc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int CFG_W      = 64;
  localparam int NUM_CFG    = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int NUM_PLANES = 6;
  localparam int PLANE_AW   = 3;
  localparam int RAD_W      = 31;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int DIVIDEND_W = DATA_W + FRAC_BITS;
  localparam int ACC_W      = PROD_W - FRAC_BITS + 2;
  localparam int ROOT_STEPS = PROD_W / 2;
  localparam int ITER_W     = $clog2(DIVIDEND_W + 1);

  typedef struct packed {
    logic [DATA_W-1:0] off;
    logic [DATA_W-1:0] nz;
    logic [DATA_W-1:0] ny;
    logic [DATA_W-1:0] nx;
  } plane_t;

  typedef struct packed {
    logic root_go;
    logic div_go;
  } rd_cmd_t;

endpackage
`default_nettype wire

[design/frustum_sphere_cull_core.sv]
`default_nettype none
// channel | valid       | stall        | payload
// in      | in_valid_i  | in_stall_o   | func_i, center_x_i/y_i/z_i, sphere_radius_i
// out     | out_valid_o | out_stall_i  | inside_res_o, build_done_o
// cfg     | cfg_we_i    | -            | cfg_idx_i, cfg_data_i
//
// a test walks the six stored planes through one shared 32x32 multiplier:
// it stops early at the first plane that culls the sphere
// a build normalises each of the six planes with the serial root and divider
// reset empties the plane store and clears the matrix, so tests pass as inside until the
// first build
// one item at a time: in_stall_o is high from transfer in until the result is taken
module frustum_sphere_cull_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            func_i,
  input  logic signed [fsc_pkg::DATA_W-1:0] center_x_i,
  input  logic signed [fsc_pkg::DATA_W-1:0] center_y_i,
  input  logic signed [fsc_pkg::DATA_W-1:0] center_z_i,
  input  logic [fsc_pkg::RAD_W-1:0]       sphere_radius_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            inside_res_o,
  output logic                            build_done_o,
  input  logic                            cfg_we_i,
  input  logic [fsc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fsc_pkg::CFG_W-1:0]       cfg_data_i
);
  import fsc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_B_COMP, S_B_SQ, S_B_ROOT, S_B_DIV, S_B_WR,
    S_T_RD, S_T_MAC, S_T_CMP, S_OUT
  } state_e;

  state_e                    state_q;
  logic [CFG_W-1:0]          cfg_q [NUM_CFG];
  logic [PLANE_AW-1:0]       plane_q;
  logic [1:0]                step_q;
  logic signed [DATA_W-1:0]  comp_q [4];
  logic [DATA_W-1:0]         nrm_q [4];
  logic [PROD_W-1:0]         sq_q;
  logic [DATA_W-1:0]         len_q;
  logic signed [DATA_W-1:0]  cx_q, cy_q, cz_q;
  logic [RAD_W-1:0]          rad_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [PROD_W-1:0]  prod_q;
  rd_cmd_t                   cmd_q;
  logic                      out_valid_q, inside_q, build_q;

  logic signed [DATA_W-1:0]  comp_nx [4];
  logic signed [DATA_W-1:0]  mul_a, mul_b;
  logic signed [DATA_W-1:0]  div_comp;
  logic [DATA_W-1:0]         div_mag;
  logic [DATA_W-1:0]         quot_sat;
  logic signed [ACC_W-1:0]   prod_sh;
  logic signed [ACC_W-1:0]   neg_rad;
  plane_t                    rdata, wdata;
  logic                      rd_done;
  logic [DATA_W-1:0]         root;
  logic [DIVIDEND_W-1:0]     quot;

  function automatic logic signed [DATA_W-1:0] sat_add(
    input logic signed [DATA_W-1:0] a,
    input logic signed [DATA_W-1:0] b,
    input logic                     sub
  );
    logic signed [DATA_W:0] s;
    s = sub ? ((DATA_W+1)'(a) - (DATA_W+1)'(b)) : ((DATA_W+1)'(a) + (DATA_W+1)'(b));
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
    return s[DATA_W-1:0];
  endfunction

  // raw plane i: row 3 plus row i/2 for even i, minus it for odd i
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic signed [DATA_W-1:0] w3, wr;
      w3 = cfg_q[2*c+1][CFG_W-1:DATA_W];
      case (plane_q[2:1])
        2'd1:    wr = cfg_q[2*c][CFG_W-1:DATA_W];
        2'd2:    wr = cfg_q[2*c+1][DATA_W-1:0];
        default: wr = cfg_q[2*c][DATA_W-1:0];
      endcase
      comp_nx[c] = sat_add(w3, wr, plane_q[0]);
    end
  end

  always_comb begin
    case (state_q)
      S_T_MAC: begin
        case (step_q)
          2'd0:    begin mul_a = rdata.nx; mul_b = cx_q; end
          2'd1:    begin mul_a = rdata.ny; mul_b = cy_q; end
          default: begin mul_a = rdata.nz; mul_b = cz_q; end
        endcase
      end
      default: begin
        mul_a = comp_q[step_q];
        mul_b = comp_q[step_q];
      end
    endcase
  end

  always_comb begin
    div_comp = comp_q[step_q];
    div_mag  = div_comp[DATA_W-1] ? DATA_W'(-div_comp) : DATA_W'(div_comp);
    if (quot[DIVIDEND_W-1:DATA_W-1] != '0) begin
      quot_sat = div_comp[DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                    : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      quot_sat = div_comp[DATA_W-1] ? DATA_W'(-quot[DATA_W-1:0]) : quot[DATA_W-1:0];
    end
    prod_sh = ACC_W'(prod_q >>> FRAC_BITS);
    neg_rad = -$signed({{(ACC_W-RAD_W){1'b0}}, rad_q});
    wdata   = '{off: nrm_q[3], nz: nrm_q[2], ny: nrm_q[1], nx: nrm_q[0]};
  end

  fsc_plane_ram u_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (state_q == S_B_WR),
    .waddr_i (plane_q),
    .wdata_i (wdata),
    .re_i    (state_q == S_T_RD),
    .raddr_i (plane_q),
    .rdata_o (rdata)
  );

  fsc_root_div u_root_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_q),
    .radicand_i (sq_q),
    .dividend_i ({div_mag, {FRAC_BITS{1'b0}}}),
    .divisor_i  (len_q),
    .done_o     (rd_done),
    .root_o     (root),
    .quot_o     (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_CFG))) begin
      cfg_q[cfg_idx_i[$clog2(NUM_CFG)-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      plane_q     <= '0;
      step_q      <= '0;
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
      build_q     <= 1'b0;
      sq_q        <= '0;
      len_q       <= '0;
      acc_q       <= '0;
      cx_q        <= '0;
      cy_q        <= '0;
      cz_q        <= '0;
      rad_q       <= '0;
      for (int c = 0; c < 4; c++) begin
        comp_q[c] <= '0;
        nrm_q[c]  <= '0;
      end
    end else begin
      cmd_q <= '0;
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cx_q    <= center_x_i;
            cy_q    <= center_y_i;
            cz_q    <= center_z_i;
            rad_q   <= sphere_radius_i;
            plane_q <= '0;
            state_q <= func_i ? S_T_RD : S_B_COMP;
          end
        end
        S_B_COMP: begin
          for (int c = 0; c < 4; c++) begin
            comp_q[c] <= comp_nx[c];
          end
          sq_q    <= '0;
          step_q  <= '0;
          state_q <= S_B_SQ;
        end
        S_B_SQ: begin
          // product of the previous step comes from a register, so each step sums the one before it
          if (step_q != 2'd0) begin
            sq_q <= sq_q + $unsigned(prod_q);
          end
          step_q <= step_q + 1'b1;
          if (step_q == 2'd3) begin
            cmd_q.root_go <= 1'b1;
            state_q       <= S_B_ROOT;
          end
        end
        S_B_ROOT: begin
          if (rd_done) begin
            len_q <= root;
            if (root == '0) begin
              for (int c = 0; c < 4; c++) begin
                nrm_q[c] <= comp_q[c];
              end
              state_q <= S_B_WR;
            end else begin
              step_q       <= '0;
              cmd_q.div_go <= 1'b1;
              state_q      <= S_B_DIV;
            end
          end
        end
        S_B_DIV: begin
          if (rd_done) begin
            nrm_q[step_q] <= quot_sat;
            if (step_q == 2'd3) begin
              state_q <= S_B_WR;
            end else begin
              step_q       <= step_q + 1'b1;
              cmd_q.div_go <= 1'b1;
            end
          end
        end
        S_B_WR: begin
          if (plane_q == PLANE_AW'(NUM_PLANES - 1)) begin
            out_valid_q <= 1'b1;
            inside_q    <= 1'b0;
            build_q     <= 1'b1;
            state_q     <= S_OUT;
          end else begin
            plane_q <= plane_q + 1'b1;
            state_q <= S_B_COMP;
          end
        end
        S_T_RD: begin
          step_q  <= '0;
          state_q <= S_T_MAC;
        end
        S_T_MAC: begin
          if (step_q == 2'd0) begin
            acc_q <= ACC_W'($signed(rdata.off));
          end else begin
            acc_q <= acc_q + prod_sh;
          end
          step_q <= step_q + 1'b1;
          if (step_q == 2'd3) begin
            state_q <= S_T_CMP;
          end
        end
        S_T_CMP: begin
          if (acc_q < neg_rad) begin
            out_valid_q <= 1'b1;
            inside_q    <= 1'b0;
            build_q     <= 1'b0;
            state_q     <= S_OUT;
          end else if (plane_q == PLANE_AW'(NUM_PLANES - 1)) begin
            out_valid_q <= 1'b1;
            inside_q    <= 1'b1;
            build_q     <= 1'b0;
            state_q     <= S_OUT;
          end else begin
            plane_q <= plane_q + 1'b1;
            state_q <= S_T_RD;
          end
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;
  assign build_done_o = build_q;

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o)
    else $error("result pending while input side is open");

  a_build_not_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && build_done_o |-> !inside_res_o)
    else $error("build result flagged inside");

  a_unit_done_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_done |-> (state_q == S_B_ROOT) || (state_q == S_B_DIV))
    else $error("root or divide finished outside a build step");

  a_store_write_build: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_B_WR) |=> (state_q == S_OUT) || (state_q == S_B_COMP))
    else $error("plane write not followed by next plane or result");

endmodule
`default_nettype wire

[design/fsc_plane_ram.sv]
`default_nettype none
module fsc_plane_ram (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [fsc_pkg::PLANE_AW-1:0]   waddr_i,
  input  fsc_pkg::plane_t                wdata_i,
  input  logic                           re_i,
  input  logic [fsc_pkg::PLANE_AW-1:0]   raddr_i,
  output fsc_pkg::plane_t                rdata_o
);
  import fsc_pkg::*;

  plane_t                mem [NUM_PLANES];
  logic [NUM_PLANES-1:0] valid_q;
  plane_t                rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem[raddr_i];
    end
  end

  // entries not yet written read as zero planes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_vld_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : '0;

endmodule
`default_nettype wire

[design/fsc_root_div.sv]
`default_nettype none
module fsc_root_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  fsc_pkg::rd_cmd_t                 cmd_i,
  input  logic [fsc_pkg::PROD_W-1:0]       radicand_i,
  input  logic [fsc_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [fsc_pkg::DATA_W-1:0]       divisor_i,
  output logic                             done_o,
  output logic [fsc_pkg::DATA_W-1:0]       root_o,
  output logic [fsc_pkg::DIVIDEND_W-1:0]   quot_o
);
  import fsc_pkg::*;

  logic                  busy_q;
  logic                  is_div_q;
  logic                  done_q;
  logic [ITER_W-1:0]     cnt_q;
  logic [PROD_W-1:0]     v_q;
  logic [PROD_W-1:0]     res_q;
  logic [PROD_W-1:0]     bit_q;
  logic [DATA_W-1:0]     rem_q;
  logic [DATA_W-1:0]     dvs_q;
  logic [DIVIDEND_W-1:0] q_q;

  logic [PROD_W-1:0]     trial;
  logic                  r_ge;
  logic [DATA_W:0]       rem_sh;
  logic                  d_ge;
  logic [DATA_W:0]       rem_nx;

  always_comb begin
    trial  = res_q + bit_q;
    r_ge   = v_q >= trial;
    rem_sh = {rem_q, q_q[DIVIDEND_W-1]};
    d_ge   = rem_sh >= {1'b0, dvs_q};
    rem_nx = d_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      is_div_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.root_go) begin
        busy_q   <= 1'b1;
        is_div_q <= 1'b0;
        cnt_q    <= ITER_W'(ROOT_STEPS - 1);
      end else if (cmd_i.div_go) begin
        busy_q   <= 1'b1;
        is_div_q <= 1'b1;
        cnt_q    <= ITER_W'(DIVIDEND_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // the root bit by bit, or one quotient bit per cycle, while busy
  always_ff @(posedge clk_i) begin
    if (cmd_i.root_go) begin
      v_q   <= radicand_i;
      res_q <= '0;
      bit_q <= PROD_W'(1) << (PROD_W - 2);
    end else if (cmd_i.div_go) begin
      q_q   <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (is_div_q) begin
        rem_q <= rem_nx[DATA_W-1:0];
        q_q   <= {q_q[DIVIDEND_W-2:0], d_ge};
      end else begin
        if (r_ge) begin
          v_q   <= v_q - trial;
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[DATA_W-1:0];
  assign quot_o = q_q;

endmodule
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import fsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 2000;

  typedef struct packed {
    logic touch;
    logic built;
  } cull_result_t;

  typedef enum logic {
    FUNC_BUILD = 1'b0,
    FUNC_TEST  = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C0_R01 = 4'd0, REG_C0_R23 = 4'd1, REG_C1_R01 = 4'd2, REG_C1_R23 = 4'd3,
    REG_C2_R01 = 4'd4, REG_C2_R23 = 4'd5, REG_C3_R01 = 4'd6, REG_C3_R23 = 4'd7,
    REG_UNUSED = 4'd12
  } reg_idx_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = 1'b0;
  logic signed [DATA_W-1:0] center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic [RAD_W-1:0] sphere_radius_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic inside_res_o, build_done_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  frustum_sphere_cull_core uut (.*);

  initial forever #2 clk_i = ~clk_i;

  // predictor state
  logic [CFG_W-1:0] matrix_regs [NUM_CFG];
  logic signed [DATA_W-1:0] pnx [NUM_PLANES], pny [NUM_PLANES], pnz [NUM_PLANES],
                            poff [NUM_PLANES];
  cull_result_t pending_results [$];

  int errors = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int quiet_cycles = 0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic longint mat_entry(input int col, input int row);
    logic [CFG_W-1:0] r;
    r = matrix_regs[col * 2 + row / 2];
    return (row % 2) ? longint'(signed'(r[63:32])) : longint'(signed'(r[31:0]));
  endfunction

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] norm_div(input longint n, input logic [63:0] len);
    logic [63:0] mag, q;
    mag = (n < 0) ? 64'(-n) : 64'(n);
    q = (mag << FRAC_BITS) / len;
    if (q > 64'h1_0000_0000) q = 64'h1_0000_0000;
    return 32'(clamp32((n < 0) ? -longint'(q) : longint'(q)));
  endfunction

  function automatic longint floor_q(input longint v);
    return v >>> FRAC_BITS;
  endfunction

  task automatic build_frustum();
    longint comp [4];
    logic [63:0] sq, len;
    for (int i = 0; i < NUM_PLANES; i++) begin
      sq = 0;
      for (int c = 0; c < 4; c++)
        comp[c] = clamp32((i % 2) ? mat_entry(c, 3) - mat_entry(c, i / 2)
                                  : mat_entry(c, 3) + mat_entry(c, i / 2));
      for (int c = 0; c < 3; c++) sq += 64'(comp[c] * comp[c]);
      len = int_root(sq);
      if (len == 0) begin
        pnx[i] = 32'(comp[0]); pny[i] = 32'(comp[1]);
        pnz[i] = 32'(comp[2]); poff[i] = 32'(comp[3]);
      end else begin
        pnx[i] = norm_div(comp[0], len); pny[i] = norm_div(comp[1], len);
        pnz[i] = norm_div(comp[2], len); poff[i] = norm_div(comp[3], len);
      end
    end
  endtask

  function automatic logic sphere_touches(input longint cx, cy, cz, r);
    longint d;
    for (int i = 0; i < NUM_PLANES; i++) begin
      d = floor_q(longint'(pnx[i]) * cx) + floor_q(longint'(pny[i]) * cy)
        + floor_q(longint'(pnz[i]) * cz) + longint'(poff[i]);
      if (d < -r) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic send_item(input func_e f, input logic [31:0] x, y, z,
                           input logic [RAD_W-1:0] r);
    cull_result_t res;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    in_valid_i <= 1'b1;
    func_i <= f;
    center_x_i <= x; center_y_i <= y; center_z_i <= z;
    sphere_radius_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    in_valid_i <= 1'b0;
    if (f == FUNC_BUILD) begin
      build_frustum();
      res = '{touch: 1'b0, built: 1'b1};
    end else begin
      res = '{touch: sphere_touches(longint'(signed'(x)), longint'(signed'(y)),
                                    longint'(signed'(z)), longint'(r)),
              built: 1'b0};
    end
    pending_results.push_back(res);
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < NUM_CFG) matrix_regs[idx] = val;
    @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_q();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0000;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  task automatic load_matrix(input int style);
    logic [31:0] lo, hi;
    for (int i = 0; i < NUM_CFG; i++) begin
      case (style)
        0: begin lo = 0; hi = 0; end
        1: begin lo = 32'h7fff_ffff; hi = 32'h8000_0000; end
        2: begin lo = 32'h8000_0000; hi = 32'h7fff_ffff; end
        3: begin lo = 32'hffff_ffff; hi = 32'hffff_ffff; end
        default: begin lo = rand_q(); hi = rand_q(); end
      endcase
      write_reg(reg_idx_e'(i), {hi, lo});
    end
  endtask

  task automatic random_sphere();
    send_item(FUNC_TEST, rand_q(), rand_q(), rand_q(),
              ($urandom_range(3) == 0) ? RAD_W'($urandom) : RAD_W'($urandom_range(0, 8 << 16)));
  endtask

  task automatic test_before_build();
    send_item(FUNC_TEST, 32'h7fff_ffff, 32'h8000_0000, 32'h0, '0);
    send_item(FUNC_TEST, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, '1);
    wait_drained();
  endtask

  task automatic test_directed();
    // identity-like matrix: unit cube frustum
    write_reg(REG_C0_R01, {32'h0, 32'h0001_0000});
    write_reg(REG_C0_R23, 64'h0);
    write_reg(REG_C1_R01, {32'h0001_0000, 32'h0});
    write_reg(REG_C1_R23, 64'h0);
    write_reg(REG_C2_R01, 64'h0);
    write_reg(REG_C2_R23, {32'h0, 32'h0001_0000});
    write_reg(REG_C3_R01, 64'h0);
    write_reg(REG_C3_R23, {32'h0001_0000, 32'h0});
    write_reg(REG_UNUSED, '1);
    send_item(FUNC_BUILD, '0, '0, '0, '0);
    send_item(FUNC_TEST, 32'h0, 32'h0, 32'h0, '0);
    send_item(FUNC_TEST, 32'h0003_0000, 32'h0, 32'h0, 31'h0001_0000);
    send_item(FUNC_TEST, 32'h0003_0000, 32'h0, 32'h0, 31'h0003_0000);
    send_item(FUNC_TEST, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, '1);
    send_item(FUNC_TEST, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0);
    wait_drained();
    for (int s = 0; s < 4; s++) begin
      // zero-length normals and saturating sums
      load_matrix(s);
      send_item(FUNC_BUILD, '1, '1, '1, '1);
      send_item(FUNC_TEST, 32'h0, 32'h0, 32'h0, '0);
      send_item(FUNC_TEST, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, '1);
      wait_drained();
    end
  endtask

  task automatic test_random(input int n);
    for (int k = 0; k < n; k++) begin
      load_matrix(4);
      send_item(FUNC_BUILD, $urandom, $urandom, $urandom, RAD_W'($urandom));
      repeat (30) random_sphere();
      wait_drained();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    cull_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (inside_res_o !== want.touch)
          report_mismatch($sformatf("inside_res %b, want %b", inside_res_o, want.touch));
        if (build_done_o !== want.built)
          report_mismatch($sformatf("build_done %b, want %b", build_done_o, want.built));
      end
    end
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_idle_pct);

  // watchdog on transfers
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    foreach (matrix_regs[i]) matrix_regs[i] = '0;
    foreach (pnx[i]) begin
      pnx[i] = 0; pny[i] = 0; pnz[i] = 0; poff[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 9; recv_idle_pct = 65;
    test_before_build();
    test_directed();
    test_random(17);
    send_idle_pct = 65; recv_idle_pct = 9;
    test_random(17);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(17);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
